@@ rtl/scs_pkg.sv @@
package scs_pkg;

    localparam int CAPACITY   = 64;
    localparam int COORD_BITS = 8;

    // fixed widths of the channel fields
    localparam int FIELD_BITS = 8;
    localparam int DATA_BITS  = 32;

    // coordinate bits kept in the table
    localparam int KEY_BITS  = (COORD_BITS < FIELD_BITS) ? COORD_BITS : FIELD_BITS;
    localparam int IDX_BITS  = $clog2(CAPACITY);
    localparam int CNT_BITS  = $clog2(CAPACITY + 1);
    localparam int ENTRY_BITS = 2 * KEY_BITS + DATA_BITS;

    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    typedef logic [1:0] status_t;
    localparam status_t STATUS_OK           = 2'd0;
    localparam status_t STATUS_ZERO_IGNORED = 2'd1;
    localparam status_t STATUS_FULL_DROPPED = 2'd2;

    typedef struct packed {
        logic start;
        logic scan_en;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic zero_write;
        logic scan_done;
        logic out_free;
    } stat_t;

endpackage

@@ rtl/scs_req_if.sv @@
interface scs_req_if;
    import scs_pkg::*;

    logic                        valid;
    logic                        ready;
    logic                        kind;
    logic [FIELD_BITS-1:0]       row_index;
    logic [FIELD_BITS-1:0]       col_index;
    logic signed [DATA_BITS-1:0] write_data;

    modport source (output valid, kind, row_index, col_index, write_data, input ready);
    modport sink   (input valid, kind, row_index, col_index, write_data, output ready);
endinterface

@@ rtl/scs_rsp_if.sv @@
interface scs_rsp_if;
    import scs_pkg::*;

    logic                        valid;
    logic                        ready;
    logic signed [DATA_BITS-1:0] read_data;
    logic                        hit;
    logic [1:0]                  status;

    modport source (output valid, read_data, hit, status, input ready);
    modport sink   (input valid, read_data, hit, status, output ready);
endinterface

@@ rtl/scs_ram.sv @@
module scs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ rtl/scs_ctrl.sv @@
module scs_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  scs_pkg::stat_t stat,
    output scs_pkg::cmd_t  cmd
);
    import scs_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next  = state_reg;
        in_ready    = 1'b0;
        cmd         = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.start = in_valid;
                if (in_valid)
                begin
                    // a zero write touches nothing, skip the scan
                    state_next = stat.zero_write ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_en = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end
endmodule

@@ rtl/scs_datapath.sv @@
module scs_datapath (
    input  logic           clk,
    input  logic           rst_n,
    scs_req_if.sink        req,
    scs_rsp_if.source      rsp,
    input  scs_pkg::cmd_t  cmd,
    output scs_pkg::stat_t stat
);
    import scs_pkg::*;

    // request held for the whole item
    logic                  kind_reg;
    logic [KEY_BITS-1:0]   row_reg;
    logic [KEY_BITS-1:0]   col_reg;
    logic [DATA_BITS-1:0]  data_reg;

    // scan pipeline: issue a read, compare in the next cycle
    logic [CNT_BITS-1:0]   issue_idx_reg, issue_idx_next;
    logic                  cmp_valid_reg, cmp_valid_next;
    logic [IDX_BITS-1:0]   cmp_idx_reg, cmp_idx_next;
    logic                  found_reg, found_next;
    logic [IDX_BITS-1:0]   found_idx_reg, found_idx_next;
    logic [DATA_BITS-1:0]  found_val_reg, found_val_next;

    logic [CNT_BITS-1:0]   count_reg, count_next;

    logic                  out_valid_reg, out_valid_next;
    logic [DATA_BITS-1:0]  out_data_reg, out_data_next;
    logic                  out_hit_reg, out_hit_next;
    status_t               out_status_reg, out_status_next;

    logic                  issue_ok;
    logic                  entry_match;
    logic                  ram_we;
    logic [IDX_BITS-1:0]   ram_waddr;
    logic [ENTRY_BITS-1:0] ram_rdata;
    logic [KEY_BITS-1:0]   ent_row;
    logic [KEY_BITS-1:0]   ent_col;
    logic [DATA_BITS-1:0]  ent_val;

    scs_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (CAPACITY)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({row_reg, col_reg, data_reg}),
        .raddr (issue_idx_reg[IDX_BITS-1:0]),
        .rdata (ram_rdata)
    );

    assign ent_row = ram_rdata[ENTRY_BITS-1 -: KEY_BITS];
    assign ent_col = ram_rdata[DATA_BITS +: KEY_BITS];
    assign ent_val = ram_rdata[DATA_BITS-1:0];

    assign issue_ok    = cmd.scan_en && !found_reg && (issue_idx_reg < count_reg);
    assign entry_match = cmp_valid_reg && (ent_row == row_reg) && (ent_col == col_reg);

    assign stat.zero_write = (req.kind == KIND_WRITE) && (req.write_data == '0);
    assign stat.scan_done  = found_reg || (!cmp_valid_reg && (issue_idx_reg == count_reg));
    assign stat.out_free   = !out_valid_reg || rsp.ready;

    always_comb
    begin
        issue_idx_next  = issue_idx_reg;
        cmp_valid_next  = issue_ok;
        cmp_idx_next    = issue_idx_reg[IDX_BITS-1:0];
        found_next      = found_reg;
        found_idx_next  = found_idx_reg;
        found_val_next  = found_val_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        out_hit_next    = out_hit_reg;
        out_status_next = out_status_reg;
        ram_we          = 1'b0;
        ram_waddr       = count_reg[IDX_BITS-1:0];

        if (cmd.start)
        begin
            issue_idx_next = '0;
            cmp_valid_next = 1'b0;
            found_next     = 1'b0;
        end
        else
        begin
            if (issue_ok)
            begin
                issue_idx_next = issue_idx_reg + CNT_BITS'(1);
            end
            // first match wins, later ones in flight are dropped
            if (entry_match && !found_reg)
            begin
                found_next     = 1'b1;
                found_idx_next = cmp_idx_reg;
                found_val_next = ent_val;
            end
        end

        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.commit)
        begin
            out_valid_next  = 1'b1;
            out_data_next   = '0;
            out_hit_next    = 1'b0;
            out_status_next = STATUS_OK;
            if (kind_reg == KIND_READ)
            begin
                out_hit_next  = found_reg;
                out_data_next = found_reg ? found_val_reg : '0;
            end
            else if (data_reg == '0)
            begin
                out_status_next = STATUS_ZERO_IGNORED;
            end
            else if (found_reg)
            begin
                out_hit_next = 1'b1;
                ram_we       = 1'b1;
                ram_waddr    = found_idx_reg;
            end
            else if (count_reg < CNT_BITS'(CAPACITY))
            begin
                ram_we     = 1'b1;
                count_next = count_reg + CNT_BITS'(1);
            end
            else
            begin
                out_status_next = STATUS_FULL_DROPPED;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmp_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            issue_idx_reg <= '0;
        end
        else
        begin
            cmp_valid_reg <= cmp_valid_next;
            found_reg     <= found_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            issue_idx_reg <= issue_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            kind_reg <= req.kind;
            row_reg  <= req.row_index[KEY_BITS-1:0];
            col_reg  <= req.col_index[KEY_BITS-1:0];
            data_reg <= req.write_data;
        end
        cmp_idx_reg    <= cmp_idx_next;
        found_idx_reg  <= found_idx_next;
        found_val_reg  <= found_val_next;
        out_data_reg   <= out_data_next;
        out_hit_reg    <= out_hit_next;
        out_status_reg <= out_status_next;
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.read_data = out_data_reg;
    assign rsp.hit       = out_hit_reg;
    assign rsp.status    = out_status_reg;
endmodule

@@ rtl/sparse_coordinate_store.sv @@
// Flow: a request is taken in idle, then the scan reads one stored entry per cycle from the
// table RAM until a hit or the end of the count, and the result is committed once the output
// slot is free; a zero write skips the scan.
// Requests: one at a time; a new request is taken only after the previous result is
// registered, and may be taken while it waits.
// Reset: rst_n clears the entry count and all control state; table contents are
// left as they are, and entries at or above the count are never compared.
module sparse_coordinate_store (
    input  logic      clk,
    input  logic      rst_n,
    scs_req_if.sink   req,
    scs_rsp_if.source rsp
);
    import scs_pkg::*;

    cmd_t  cmd;
    stat_t stat;
    logic  in_ready;

    assign req.ready = in_ready;

    scs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    scs_datapath u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cmd   (cmd),
        .stat  (stat)
    );

    // one request in flight at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("request taken while another is in progress");

    a_commit_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> stat.out_free)
        else $error("result committed over an untaken result");

    a_start_commit_apart: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.start && (cmd.commit || cmd.scan_en)))
        else $error("start overlaps scan or commit");

    a_result_after_commit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> rsp.valid)
        else $error("commit did not raise the result");
endmodule
